### rtl/core/tmcw_pkg.sv
// Shared types and constants of the text-mode console writer.
`default_nettype none

package tmcw_pkg;

  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [7:0]  SPACE_CODE   = 8'h20;
  localparam logic [15:0] RESET_CELL   = 16'h0720;
  localparam logic [7:0]  RESET_COLOR  = 8'h07;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_NEWLINE,
    KIND_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_BLANK
  } back_state_e;

endpackage

`default_nettype wire

### rtl/core/tmcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/tmcw_front.sv
// Input side: takes beats, classifies them and queues them for the engine.
`default_nettype none

module tmcw_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [23:0]   s_axis_tdata,  // [7:0] char_code, [18:8] cell_address
  input  wire logic          s_axis_tuser,  // [0] command
  input  wire logic          hold_i,
  output logic               cmd_valid_o,
  output tmcw_pkg::cmd_t     cmd_o,
  input  wire logic          cmd_pop_i
);

  import tmcw_pkg::*;

  cmd_t       queue_q [2];
  logic       head_q, head_d;
  logic       tail_q, tail_d;
  logic [1:0] count_q, count_d;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in.char_code    = s_axis_tdata[7:0];
    cmd_in.cell_address = s_axis_tdata[18:8];
    if (s_axis_tuser) begin
      cmd_in.kind = KIND_READ;
    end else if (s_axis_tdata[7:0] == NEWLINE_CODE) begin
      cmd_in.kind = KIND_NEWLINE;
    end else begin
      cmd_in.kind = KIND_CHAR;
    end
  end

  assign s_axis_tready = (count_q != 2'd2) && !hold_i;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (count_q != 2'd0);
  assign cmd_o         = queue_q[head_q];

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push) begin
      tail_d = ~tail_q;
    end
    if (cmd_pop_i) begin
      head_d = ~head_q;
    end
    if (push && !cmd_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= 1'b0;
      tail_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[tail_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tmcw_back.sv
// Execution engine: cursor, cell buffer, row blanking and result register.
`default_nettype none

module tmcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    text_color_i,
  input  wire logic          cmd_valid_i,
  input  wire tmcw_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               clearing_o,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output logic [15:0]        cell_data_o,
  output logic [10:0]        cursor_position_o
);

  import tmcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0]    ROW_STEP  = AW'(COLUMNS);

  back_state_e      state_q, state_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [AW-1:0]    base_q, base_d;
  logic [COL_W-1:0] blk_q, blk_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic             in_range_q, in_range_d;
  logic             out_valid_q, out_valid_d;
  logic [15:0]      out_data_q, out_data_d;
  logic [10:0]      out_pos_q, out_pos_d;

  logic [ROW_W-1:0] row_adv;
  logic [AW-1:0]    base_adv;
  logic             out_free;
  logic             issue;
  logic [AW-1:0]    pos_next;
  logic [AW+10:0]   pos_wide;
  logic [AW+10:0]   addr_wide;
  logic             addr_ok;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [15:0]      mem_wdata;
  logic             mem_re;
  logic [15:0]      mem_rdata;

  tmcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (addr_wide[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign row_adv   = (row_q == LAST_ROW) ? '0 : row_q + ROW_W'(1);
  assign base_adv  = (row_q == LAST_ROW) ? '0 : base_q + ROW_STEP;
  assign out_free  = !out_valid_q || res_ready_i;
  assign addr_wide = {AW'(0), cmd_i.cell_address};
  assign addr_ok   = ({21'd0, cmd_i.cell_address} < 32'(CELLS));

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    base_d      = base_q;
    blk_d       = blk_q;
    clr_d       = clr_q;
    in_range_d  = in_range_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_data_d  = out_data_q;
    out_pos_d   = out_pos_q;
    mem_we      = 1'b0;
    mem_waddr   = base_q + AW'(col_q);
    mem_wdata   = {text_color_i, cmd_i.char_code};
    mem_re      = 1'b0;
    cmd_pop_o   = 1'b0;
    issue       = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = RESET_CELL;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            KIND_READ: begin
              mem_re     = addr_ok;
              in_range_d = addr_ok;
              state_d    = ST_READ;
            end
            KIND_NEWLINE: begin
              issue      = 1'b1;
              out_data_d = '0;
              col_d      = '0;
              row_d      = row_adv;
              base_d     = base_adv;
              blk_d      = '0;
              state_d    = ST_BLANK;
            end
            default: begin
              issue      = 1'b1;
              out_data_d = '0;
              mem_we     = 1'b1;
              if (col_q == LAST_COL) begin
                col_d   = '0;
                row_d   = row_adv;
                base_d  = base_adv;
                blk_d   = '0;
                state_d = ST_BLANK;
              end else begin
                col_d = col_q + COL_W'(1);
              end
            end
          endcase
        end
      end
      ST_READ: begin
        issue      = 1'b1;
        out_data_d = in_range_q ? mem_rdata : '0;
        state_d    = ST_IDLE;
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = base_q + AW'(blk_q);
        mem_wdata = {text_color_i, SPACE_CODE};
        blk_d     = blk_q + COL_W'(1);
        if (blk_q == LAST_COL) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    pos_next = base_d + AW'(col_d);
    pos_wide = {11'd0, pos_next};
    if (issue) begin
      out_valid_d = 1'b1;
      out_pos_d   = pos_wide[10:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      blk_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      base_q      <= base_d;
      blk_q       <= blk_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_range_q <= in_range_d;
    out_data_q <= out_data_d;
    out_pos_q  <= out_pos_d;
  end

  assign clearing_o        = (state_q == ST_CLEAR);
  assign res_valid_o       = out_valid_q;
  assign cell_data_o       = out_data_q;
  assign cursor_position_o = out_pos_q;

endmodule

`default_nettype wire

### rtl/core/text_mode_console_writer.sv
// Top level of the text-mode console writer.
// A character-cell console of COLUMNS x ROWS cells held in one RAM, with a cursor. A put beat
// with an ordinary character writes one cell, so such beats stream at one per cycle while the
// result output is not stalled. A newline, or a character that wraps the column, blanks the new
// row through the single RAM write port, one cell a cycle, before the next beat is carried out. A
// read beat passes through a read state, as the RAM read is registered. After reset the buffer is
// filled with blank cells in a sweep over all COLUMNS*ROWS cells (2000 by default), during which
// no beat is taken; text_color may be written at any idle time. Each beat gives one result beat,
// held in an output register, with the cursor position after that beat.
`default_nettype none

module text_mode_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [7:0] char_code, [18:8] cell_address
  input  wire logic        s_axis_tuser,  // [0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // [15:0] cell_data, [26:16] cursor_position
);

  import tmcw_pkg::*;

  logic [7:0]  color_q;
  logic        cmd_valid;
  cmd_t        cmd;
  logic        cmd_pop;
  logic        clearing;
  logic [15:0] cell_data;
  logic [10:0] cursor_position;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= RESET_COLOR;
    end else if (cfg_we_i) begin
      color_q <= cfg_wdata_i;
    end
  end

  tmcw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .hold_i        (clearing),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  tmcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .text_color_i      (color_q),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .cmd_pop_o         (cmd_pop),
    .clearing_o        (clearing),
    .res_valid_o       (m_axis_tvalid),
    .res_ready_i       (m_axis_tready),
    .cell_data_o       (cell_data),
    .cursor_position_o (cursor_position)
  );

  assign m_axis_tdata = {5'd0, cursor_position, cell_data};

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench of the text-mode console writer: character streams, reads and colours.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tmcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int PHASE_BEATS = 280;
  localparam int CYCLE_LIMIT = 800_000;

  typedef enum bit {
    CMD_PUT,
    CMD_READ
  } console_cmd_e;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [10:0] cursor_position;
  } console_result_t;

  class console_scoreboard;
    logic [15:0]     cells [CELLS];
    int unsigned     row;
    int unsigned     col;
    logic [7:0]      color;
    console_result_t pending_results [$];
    int unsigned     errors;

    function new();
      foreach (cells[i]) cells[i] = RESET_CELL;
      row = 0;
      col = 0;
      color = RESET_COLOR;
      errors = 0;
    endfunction

    function void set_color(logic [7:0] value);
      color = value;
    endfunction

    function int unsigned cursor();
      return row * COLUMNS + col;
    endfunction

    function void advance_row();
      row = (row + 1 >= ROWS) ? 0 : row + 1;
      for (int x = 0; x < COLUMNS; x++) cells[row * COLUMNS + x] = {color, SPACE_CODE};
    endfunction

    function void note_beat(console_cmd_e cmd, logic [7:0] ch, logic [10:0] addr);
      console_result_t res;
      res.cell_data = '0;
      if (cmd == CMD_READ) begin
        if (addr < CELLS) res.cell_data = cells[addr];
      end else if (ch == NEWLINE_CODE) begin
        advance_row();
        col = 0;
      end else begin
        cells[cursor()] = {color, ch};
        col = (col + 1 >= COLUMNS) ? 0 : col + 1;
        if (col == 0) advance_row();
      end
      res.cursor_position = 11'(cursor());
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [15:0] data, logic [10:0] pos);
      console_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: cell_data %h cursor_position %0d", data, pos);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (data !== exp_res.cell_data) begin
        $error("cell_data: expected %h, actual %h", exp_res.cell_data, data);
        errors++;
      end
      if (pos !== exp_res.cursor_position) begin
        $error("cursor_position: expected %0d, actual %0d", exp_res.cursor_position, pos);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [7:0] char_code, [18:8] cell_address
  logic        s_axis_tuser = 1'b0;  // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // [15:0] cell_data, [26:16] cursor_position

  console_scoreboard board = new();
  bit                quiet = 1'b0;
  int unsigned       cycles = 0;
  int unsigned       stall_left = 0;

  text_mode_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata[15:0], m_axis_tdata[26:16]);
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && rst_ni && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(console_cmd_e cmd, logic [7:0] ch, logic [10:0] addr);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {5'b0, addr, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_beat(cmd, ch, addr);
    @(negedge clk_i);
  endtask

  task automatic put_char(logic [7:0] ch);
    send_beat(CMD_PUT, ch, 11'($urandom));
  endtask

  task automatic read_cell(logic [10:0] addr);
    send_beat(CMD_READ, 8'($urandom), addr);
  endtask

  // Hold off until every result is back, then write the colour.
  task automatic drain_and_set_color(logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(negedge clk_i);
    repeat (COLUMNS + 4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    board.set_color(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] ch;
    do ch = 8'($urandom); while (ch == NEWLINE_CODE);
    return ch;
  endfunction

  task automatic random_phase(int unsigned beats);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    int          near;
    sent = 0;
    while (sent < beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(75, 170) : $urandom_range(0, 30);
        repeat (len) put_char(text_byte());
        sent += len;
        if ($urandom_range(0, 4) != 0) begin
          put_char(NEWLINE_CODE);
          sent++;
        end
      end else if (pick < 85) begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          pick = $urandom_range(0, 99);
          if (pick < 50) begin
            near = int'(board.cursor()) - int'($urandom_range(0, 3));
            read_cell(11'((near < 0) ? 0 : near));
          end else if (pick < 85) begin
            read_cell(11'($urandom_range(0, CELLS - 1)));
          end else begin
            read_cell(11'($urandom_range(CELLS, 2047)));
          end
        end
        sent += len;
      end else begin
        send_beat(console_cmd_e'($urandom_range(0, 1)), 8'($urandom), 11'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    drain_and_set_color(8'h1F);
    read_cell(11'd0);
    read_cell(11'(CELLS - 1));
    read_cell(11'(CELLS));
    read_cell(11'h7FF);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h41);
    read_cell(11'd0);
    read_cell(11'd1);
    read_cell(11'd2);
    put_char(NEWLINE_CODE);
    read_cell(11'(COLUMNS));
    read_cell(11'd3);
    put_char(NEWLINE_CODE);
    put_char(NEWLINE_CODE);
    put_char(8'h0B);
    put_char(8'h09);
    put_char(8'h0D);
    read_cell(11'(3 * COLUMNS));
    read_cell(11'(CELLS + 1));

    random_phase(PHASE_BEATS);
    drain_and_set_color(8'h00);
    random_phase(PHASE_BEATS);
    drain_and_set_color(8'hFF);
    random_phase(PHASE_BEATS);
    drain_and_set_color(RESET_COLOR);
    random_phase(PHASE_BEATS);
    drain_and_set_color(8'($urandom));
    random_phase(PHASE_BEATS);
    drain_and_set_color(8'($urandom));
    quiet = 1'b1;
    random_phase(PHASE_BEATS);

    s_axis_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * COLUMNS) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/core/tmcw_pkg.sv
rtl/core/tmcw_ram.sv
rtl/core/tmcw_front.sv
rtl/core/tmcw_back.sv
rtl/core/text_mode_console_writer.sv
tb/sv/tb_top.sv
